// ===== rtl/tpwc_pkg.sv =====
// ============================================================================
// Tuner PLL word calculator package
// Shared types, register indexes and reset values of the divider word block.
// ============================================================================
`default_nettype none

package tpwc_pkg;

    // Widths of the datapath and of the configuration port.
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BANDS_W    = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DIV_STEPS  = 32;
    localparam int unsigned OUT_DATA_W = 32;

    // Quotient bits that make up the divider word.
    localparam int unsigned DIV_KEEP_W = 15;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_STEP    = 3'd0,
        REG_IF_OFFSET    = 3'd1,
        REG_RESOLUTION   = 3'd2,
        REG_THRESH_LOW   = 3'd3,
        REG_THRESH_HIGH  = 3'd4,
        REG_BAND_BYTES   = 3'd5,
        REG_CONTROL_BYTE = 3'd6,
        REG_MODE_MASK    = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  RST_FREQ_STEP    = 16'd1;
    localparam logic [WORD_W-1:0]  RST_IF_OFFSET    = 32'd479500000;
    localparam logic [WORD_W-1:0]  RST_RESOLUTION   = 32'd125000;
    localparam logic [WORD_W-1:0]  RST_THRESH_LOW   = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]  RST_THRESH_HIGH  = 32'hFFFF_FFFF;
    localparam logic [BANDS_W-1:0] RST_BAND_BYTES   = 24'h30_3030;
    localparam logic [BYTE_W-1:0]  RST_CONTROL_BYTE = 8'h95;
    localparam logic [BYTE_W-1:0]  RST_MODE_MASK    = 8'h00;

    // Payload carried through the divider stages.
    typedef struct packed {
        logic [WORD_W-1:0] rem;   // partial remainder
        logic [WORD_W-1:0] dq;    // dividend bits still to go, quotient bits shifted in
        logic [BYTE_W-1:0] band;  // masked band byte riding along
    } div_data_t;

endpackage : tpwc_pkg

`default_nettype wire

// ===== rtl/tpwc_front.sv =====
// ============================================================================
// Tuner PLL word calculator front end
// Scales the frequency to hertz, picks the band byte and adds the IF offset.
// ============================================================================
`default_nettype none

module tpwc_front
    import tpwc_pkg::*;
#(
    parameter int unsigned FREQ_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [FREQ_WIDTH-1:0]  freq,
    input  wire logic [STEP_W-1:0]      freq_step,
    input  wire logic [WORD_W-1:0]      if_offset,
    input  wire logic [WORD_W-1:0]      thresh_low,
    input  wire logic [WORD_W-1:0]      thresh_high,
    input  wire logic [BANDS_W-1:0]     band_bytes,
    input  wire logic [BYTE_W-1:0]      mode_mask,
    output logic                        out_valid,
    output logic [WORD_W-1:0]           sum,
    output logic [BYTE_W-1:0]           band
);

    localparam int unsigned PROD_W = FREQ_WIDTH + STEP_W;

    logic [PROD_W-1:0] prod_full;
    logic              hz_valid_reg;
    logic [WORD_W-1:0] hz_reg;
    logic              sum_valid_reg;
    logic [WORD_W-1:0] sum_reg;
    logic [BYTE_W-1:0] band_reg;
    logic [BYTE_W-1:0] band_next;

    // Stage one: scale to hertz, keeping the low word of the product.
    assign prod_full = {{STEP_W{1'b0}}, freq} * {{FREQ_WIDTH{1'b0}}, freq_step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            hz_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hz_reg <= prod_full[WORD_W-1:0];
        end
    end

    // Band selection against the two thresholds, with the mode bits cleared.
    always_comb
    begin
        if (hz_reg < thresh_low)
        begin
            band_next = band_bytes[BYTE_W-1:0];
        end
        else if (hz_reg < thresh_high)
        begin
            band_next = band_bytes[2*BYTE_W-1:BYTE_W];
        end
        else
        begin
            band_next = band_bytes[3*BYTE_W-1:2*BYTE_W];
        end
        band_next = band_next & ~mode_mask;
    end

    // Stage two: register the band byte and the offset frequency.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_valid_reg <= hz_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= hz_reg + if_offset;
            band_reg <= band_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign band      = band_reg;

endmodule : tpwc_front

`default_nettype wire

// ===== rtl/tpwc_div_step.sv =====
// ============================================================================
// Tuner PLL word calculator divider step
// One registered restoring division step producing one quotient bit.
// ============================================================================
`default_nettype none

module tpwc_div_step
    import tpwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire div_data_t         in_data,
    input  wire logic [WORD_W-1:0] divisor,
    output logic                   out_valid,
    output div_data_t              out_data
);

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              q_bit;
    logic              valid_reg;
    div_data_t         data_reg;
    div_data_t         data_next;

    // Bring down the next dividend bit and try the subtraction.
    // A zero divisor always subtracts, which gives an all-ones quotient.
    always_comb
    begin
        trial = {in_data.rem, in_data.dq[WORD_W-1]};
        diff  = trial - {1'b0, divisor};
        q_bit = (trial >= {1'b0, divisor});
        data_next.rem  = q_bit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        data_next.dq   = {in_data.dq[WORD_W-2:0], q_bit};
        data_next.band = in_data.band;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule : tpwc_div_step

`default_nettype wire

// ===== rtl/tpwc_divider.sv =====
// ============================================================================
// Tuner PLL word calculator divider
// Chain of registered restoring steps, one quotient bit per stage.
// ============================================================================
`default_nettype none

module tpwc_divider
    import tpwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [BYTE_W-1:0] in_band,
    input  wire logic [WORD_W-1:0] divisor,
    output logic                   out_valid,
    output logic [WORD_W-1:0]      quotient,
    output logic [BYTE_W-1:0]      out_band
);

    logic      valid_chain [0:DIV_STEPS];
    div_data_t data_chain  [0:DIV_STEPS];

    // The remainder starts at zero with the whole dividend still to come.
    assign valid_chain[0]     = in_valid;
    assign data_chain[0].rem  = '0;
    assign data_chain[0].dq   = dividend;
    assign data_chain[0].band = in_band;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        tpwc_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .divisor   (divisor),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    assign out_valid = valid_chain[DIV_STEPS];
    assign quotient  = data_chain[DIV_STEPS].dq;
    assign out_band  = data_chain[DIV_STEPS].band;

endmodule : tpwc_divider

`default_nettype wire

// ===== rtl/tuner_pll_word_calc.sv =====
// ============================================================================
// Tuner PLL divider word calculator
// Turns a tuning frequency into the four tuner programming bytes.
// ============================================================================
//
// Channel  Direction  Transaction                     Handshake
// -------  ---------  ------------------------------  --------------------
// s_*      in         one frequency in step units     s_tvalid / s_tready
// m_*      out        four programming bytes, flag    m_tvalid / m_tready
// cfg_*    in         one register write              cfg_valid / cfg_ready
//
// One transaction enters per cycle whenever the output register is empty or taken.
// The path has one multiply stage, one band and offset stage, 32 restoring
// division stages and the output register.
// Reset clears all valid bits and loads the register reset values.
// All stages advance together whenever the output register is empty or taken,
// so a stall holds every stage in place and nothing is lost or repeated.
// Register writes are always accepted.
// ============================================================================
`default_nettype none

module tuner_pll_word_calc
    import tpwc_pkg::*;
#(
    parameter int unsigned FREQ_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [WORD_W-1:0]     s_tdata,    // [31:0] freq
    // Output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,    // [6:0] pll_byte_high, [14:7] pll_byte_low,
                                                   // [22:15] control_out, [30:23] band_out,
                                                   // [31] zero
    output logic                       m_tuser,    // [0] divider_overflow
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0]     cfg_data
);

    logic [STEP_W-1:0]  freq_step_reg;
    logic [WORD_W-1:0]  if_offset_reg;
    logic [WORD_W-1:0]  resolution_reg;
    logic [WORD_W-1:0]  thresh_low_reg;
    logic [WORD_W-1:0]  thresh_high_reg;
    logic [BANDS_W-1:0] band_bytes_reg;
    logic [BYTE_W-1:0]  control_byte_reg;
    logic [BYTE_W-1:0]  mode_mask_reg;

    logic               en;
    logic               front_valid;
    logic [WORD_W-1:0]  front_sum;
    logic [BYTE_W-1:0]  front_band;
    logic               div_valid;
    logic [WORD_W-1:0]  div_quot;
    logic [BYTE_W-1:0]  div_band;

    logic               out_valid_reg;
    logic [6:0]         pll_high_reg;
    logic [BYTE_W-1:0]  pll_low_reg;
    logic [BYTE_W-1:0]  band_out_reg;
    logic               ovf_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg    <= RST_FREQ_STEP;
            if_offset_reg    <= RST_IF_OFFSET;
            resolution_reg   <= RST_RESOLUTION;
            thresh_low_reg   <= RST_THRESH_LOW;
            thresh_high_reg  <= RST_THRESH_HIGH;
            band_bytes_reg   <= RST_BAND_BYTES;
            control_byte_reg <= RST_CONTROL_BYTE;
            mode_mask_reg    <= RST_MODE_MASK;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FREQ_STEP:    freq_step_reg    <= cfg_data[STEP_W-1:0];
                REG_IF_OFFSET:    if_offset_reg    <= cfg_data;
                REG_RESOLUTION:   resolution_reg   <= cfg_data;
                REG_THRESH_LOW:   thresh_low_reg   <= cfg_data;
                REG_THRESH_HIGH:  thresh_high_reg  <= cfg_data;
                REG_BAND_BYTES:   band_bytes_reg   <= cfg_data[BANDS_W-1:0];
                REG_CONTROL_BYTE: control_byte_reg <= cfg_data[BYTE_W-1:0];
                REG_MODE_MASK:    mode_mask_reg    <= cfg_data[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

    // The whole pipeline moves whenever the output register can take a result.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Scaling, band selection and offset.
    tpwc_front #(
        .FREQ_WIDTH (FREQ_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .freq        (s_tdata[FREQ_WIDTH-1:0]),
        .freq_step   (freq_step_reg),
        .if_offset   (if_offset_reg),
        .thresh_low  (thresh_low_reg),
        .thresh_high (thresh_high_reg),
        .band_bytes  (band_bytes_reg),
        .mode_mask   (mode_mask_reg),
        .out_valid   (front_valid),
        .sum         (front_sum),
        .band        (front_band)
    );

    // Division by the resolution.
    tpwc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .dividend  (front_sum),
        .in_band   (front_band),
        .divisor   (resolution_reg),
        .out_valid (div_valid),
        .quotient  (div_quot),
        .out_band  (div_band)
    );

    // Output register: split the divider word and flag a quotient above 15 bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_high_reg <= div_quot[DIV_KEEP_W-1:BYTE_W];
            pll_low_reg  <= div_quot[BYTE_W-1:0];
            band_out_reg <= div_band;
            ovf_reg      <= |div_quot[WORD_W-1:DIV_KEEP_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, band_out_reg, control_byte_reg, pll_low_reg, pll_high_reg};
    assign m_tuser  = ovf_reg;

endmodule : tuner_pll_word_calc

`default_nettype wire
